### hdl/kie_pkg.sv
// ----------------------------------------------------------------------------
// kie_pkg
// Shared types and codes for the truncated Katz index engine.
// ----------------------------------------------------------------------------
package kie_pkg;

	// input command codes
	localparam logic [1:0] CMD_EDGE  = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	// result kinds
	localparam logic KIND_DONE  = 1'b0;
	localparam logic KIND_SCORE = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_NODE_COUNT = 2'd0;
	localparam logic [1:0] REG_BETA       = 2'd1;
	localparam logic [1:0] REG_STEPS      = 2'd2;

	// reset values of the registers and the length weight, and its rounding constant
	localparam logic [6:0]  NODE_COUNT_RST = 7'd64;
	localparam logic [31:0] BETA_RST       = 32'd429496730;
	localparam logic [5:0]  STEPS_RST      = 6'd20;
	localparam logic [31:0] WEIGHT_ONE     = 32'hFFFF_FFFF;
	localparam logic [63:0] WEIGHT_ROUND   = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic [1:0] command;
		logic [5:0] node_a;
		logic [5:0] node_b;
	} kie_in_t;

	typedef struct packed {
		logic        result_kind;
		logic [63:0] pair_score;
	} kie_out_t;

	// tag travelling with one multiply-accumulate read
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} kie_tag_t;

endpackage

### hdl/kie_mac_pipe.sv
// ----------------------------------------------------------------------------
// kie_mac_pipe
// Multiply-accumulate pipeline: path x adjacency products summed over one
// row/column, then written back as the next path count and folded into the
// score entry with a read-modify-write.
// ----------------------------------------------------------------------------
module kie_mac_pipe import kie_pkg::*; #(
	parameter int IW          = 12,
	parameter int COUNT_WIDTH = 32,
	parameter int ADJ_WIDTH   = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kie_tag_t               iss,
	input  logic [IW-1:0]          iss_ix,
	input  logic [COUNT_WIDTH-1:0] path_rd,
	input  logic [ADJ_WIDTH-1:0]   adj_rd,
	input  logic [31:0]            weight,
	input  logic [63:0]            score_rd,
	output logic                   pw_en,
	output logic [IW-1:0]          pw_addr,
	output logic [COUNT_WIDTH-1:0] pw_data,
	output logic                   sr_en,
	output logic [IW-1:0]          sr_addr,
	output logic                   sw_en,
	output logic [IW-1:0]          sw_addr,
	output logic [63:0]            sw_data,
	output logic                   busy
);

	localparam int CPX = COUNT_WIDTH + ADJ_WIDTH;
	localparam int SPX = (COUNT_WIDTH + 32 > 64) ? COUNT_WIDTH + 32 : 64;
	localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

	kie_tag_t               tag_s1, tag_s2;
	logic [IW-1:0]          ix_s1, ix_s2, ix_s3, ix_s4;
	logic [COUNT_WIDTH-1:0] prod_s2, acc_q, acc_s3;
	logic                   v_s3, v_s4;
	logic [63:0]            sprod_s4;

	logic [CPX-1:0]         mp;
	logic [COUNT_WIDTH-1:0] prod;
	logic [COUNT_WIDTH-1:0] acc_base;
	logic [COUNT_WIDTH:0]   acc_sum;
	logic [COUNT_WIDTH-1:0] acc_new;
	logic [SPX-1:0]         sp;
	logic [63:0]            sprod;
	logic [64:0]            sc_sum;

	// stage 1: saturating path x adjacency product
	always_comb begin
		mp   = CPX'(path_rd) * CPX'(adj_rd);
		prod = (mp > CPX'(CMAX)) ? CMAX : mp[COUNT_WIDTH-1:0];
	end

	// stage 2: saturating accumulate
	always_comb begin
		acc_base = tag_s2.first ? '0 : acc_q;
		acc_sum  = {1'b0, acc_base} + {1'b0, prod_s2};
		acc_new  = acc_sum[COUNT_WIDTH] ? CMAX : acc_sum[COUNT_WIDTH-1:0];
	end

	// stage 3: weight x path count, saturated to 64 bits
	always_comb begin
		sp    = SPX'(weight) * SPX'(acc_s3);
		sprod = (sp > SPX'({64{1'b1}})) ? {64{1'b1}} : sp[63:0];
	end

	// stage 4: saturating score update
	assign sc_sum  = {1'b0, score_rd} + {1'b0, sprod_s4};
	assign sw_data = sc_sum[64] ? {64{1'b1}} : sc_sum[63:0];
	assign sw_en   = v_s4;
	assign sw_addr = ix_s4;

	assign pw_en   = v_s3;
	assign pw_addr = ix_s3;
	assign pw_data = acc_s3;
	assign sr_en   = v_s3;
	assign sr_addr = ix_s3;
	assign busy    = tag_s1.valid | tag_s2.valid | v_s3 | v_s4;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
		end else begin
			tag_s1 <= iss;
			tag_s2 <= tag_s1;
			v_s3   <= tag_s2.valid & tag_s2.last;
			v_s4   <= v_s3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		ix_s1    <= iss_ix;
		ix_s2    <= ix_s1;
		prod_s2  <= prod;
		if (tag_s2.valid) begin
			acc_q <= acc_new;
		end
		acc_s3   <= acc_new;
		ix_s3    <= ix_s2;
		ix_s4    <= ix_s3;
		sprod_s4 <= sprod;
	end

endmodule

### hdl/katz_index_engine_unit.sv
// ----------------------------------------------------------------------------
// katz_index_engine_unit
// Truncated Katz index over an undirected multigraph held in on-chip memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) takes one command per transaction:
// add edge, run computation or query a pair score. Output channel
// (out_valid/out_stall/out_data) carries a done result per computation and a
// score per query; edges give no result.
// Work per command, n = nodes in use:
//   add edge : two read-modify-writes of the adjacency memory
//   query    : one score memory read, then the output register
//   compute  : n*n path and score entries set up, then per step a weight
//              update, a product walk through the single read port of the
//              path and adjacency memories, and a pipeline drain
// One command is worked on at a time; in_stall is high while busy.
// After reset the adjacency memory is cleared, one entry a cycle, over all
// 2^(2*ceil(log2(MAX_NODES))) entries (4096 by default) with in_stall high;
// configuration writes are taken throughout. A result waits in the output
// register while out_stall is high; the block holds its next result until
// the register is free. Scores read before any computation are undefined.
// ----------------------------------------------------------------------------
module katz_index_engine_unit import kie_pkg::*; #(
	parameter int MAX_NODES   = 64,
	parameter int COUNT_WIDTH = 32,
	parameter int ADJ_WIDTH   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  kie_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output kie_out_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int IW  = 2 * NW;
	localparam int NCW = $clog2(MAX_NODES + 1);

	typedef enum logic [3:0] {
		CLEAR, IDLE, E_WR1, E_RD2, E_WR2, Q_OUT,
		C_INIT, C_WGT, C_MUL, C_DRAIN, C_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [6:0]  node_count_q;
	logic [31:0] beta_q;
	logic [5:0]  steps_q;

	// control
	logic [IW-1:0]    clr_q;
	logic [NW-1:0]    ea_q, eb_q;
	logic [NW-1:0]    ci_q, cj_q, gi_q, gx_q, gj_q;
	logic [5:0]       sc_q;
	logic             rb_q;
	logic             q_ok_q;
	logic [31:0]      w_q;
	kie_out_t         out_q;
	logic             out_valid_q;

	// memories
	logic [ADJ_WIDTH-1:0]   adj_mem [2**IW];
	logic [COUNT_WIDTH-1:0] path_mem [2**(IW+1)];
	logic [63:0]            score_mem [2**IW];
	logic [ADJ_WIDTH-1:0]   adj_rd_q;
	logic [COUNT_WIDTH-1:0] path_rd_q;
	logic [63:0]            score_rd_q;

	// memory port controls
	logic                   adj_re, adj_we;
	logic [IW-1:0]          adj_ra, adj_wa;
	logic [ADJ_WIDTH-1:0]   adj_wd, adj_inc;
	logic                   path_re, path_we;
	logic [IW:0]            path_ra, path_wa;
	logic [COUNT_WIDTH-1:0] path_wd;
	logic                   score_re, score_we;
	logic [IW-1:0]          score_ra, score_wa;
	logic [63:0]            score_wd;

	// helpers
	logic [NCW-1:0] n;
	logic [NW-1:0]  nm1;
	logic [NW-1:0]  na, nb;
	logic           a_ok, b_ok;
	logic           accept;
	logic           out_free;
	kie_tag_t       iss;
	logic [IW-1:0]  iss_ix;
	logic [63:0]    w_prod;

	// mac pipeline outputs
	logic                   pw_en, sr_en, sw_en, mac_busy;
	logic [IW-1:0]          pw_addr, sr_addr, sw_addr;
	logic [COUNT_WIDTH-1:0] pw_data;
	logic [63:0]            sw_data;

	// nodes in use and range checks
	always_comb begin
		n    = (32'(node_count_q) > 32'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(node_count_q);
		nm1  = NW'(n - NCW'(1));
		na   = NW'(in_data.node_a);
		nb   = NW'(in_data.node_b);
		a_ok = 32'(in_data.node_a) < 32'(n);
		b_ok = 32'(in_data.node_b) < 32'(n);
	end

	assign accept   = in_valid & ~in_stall;
	assign in_stall = (state_q != IDLE);
	assign out_free = ~out_valid_q | ~out_stall;
	assign adj_inc  = (adj_rd_q == '1) ? adj_rd_q : adj_rd_q + ADJ_WIDTH'(1);
	assign w_prod   = 64'(w_q) * 64'(beta_q) + WEIGHT_ROUND;

	// product walk tag
	always_comb begin
		iss.valid = (state_q == C_MUL);
		iss.first = (gj_q == '0);
		iss.last  = (gj_q == nm1);
		iss_ix    = {gi_q, gx_q};
	end

	// adjacency port selection
	always_comb begin
		adj_re = 1'b0;
		adj_ra = {gj_q, gx_q};
		adj_we = 1'b0;
		adj_wa = {ea_q, eb_q};
		adj_wd = adj_inc;
		unique case (state_q)
			CLEAR: begin
				adj_we = 1'b1;
				adj_wa = clr_q;
				adj_wd = '0;
			end
			IDLE: begin
				adj_re = accept & (in_data.command == CMD_EDGE);
				adj_ra = {na, nb};
			end
			E_WR1: adj_we = 1'b1;
			E_RD2: begin
				adj_re = 1'b1;
				adj_ra = {eb_q, ea_q};
			end
			E_WR2: begin
				adj_we = 1'b1;
				adj_wa = {eb_q, ea_q};
			end
			C_MUL: adj_re = 1'b1;
			default: ;
		endcase
	end

	// path and score port selection
	always_comb begin
		path_re  = (state_q == C_MUL);
		path_ra  = {rb_q, gi_q, gj_q};
		path_we  = pw_en;
		path_wa  = {~rb_q, pw_addr};
		path_wd  = pw_data;
		score_re = sr_en;
		score_ra = sr_addr;
		score_we = sw_en;
		score_wa = sw_addr;
		score_wd = sw_data;
		if (state_q == C_INIT) begin
			path_we  = 1'b1;
			path_wa  = {1'b0, ci_q, cj_q};
			path_wd  = (ci_q == cj_q) ? COUNT_WIDTH'(1) : '0;
			score_we = 1'b1;
			score_wa = {ci_q, cj_q};
			score_wd = '0;
		end
		if (state_q == IDLE) begin
			score_re = accept & (in_data.command == CMD_QUERY);
			score_ra = {na, nb};
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_wa] <= adj_wd;
		end
		if (adj_re) begin
			adj_rd_q <= adj_mem[adj_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (path_we) begin
			path_mem[path_wa] <= path_wd;
		end
		if (path_re) begin
			path_rd_q <= path_mem[path_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (score_we) begin
			score_mem[score_wa] <= score_wd;
		end
		if (score_re) begin
			score_rd_q <= score_mem[score_ra];
		end
	end

	kie_mac_pipe #(
		.IW          (IW),
		.COUNT_WIDTH (COUNT_WIDTH),
		.ADJ_WIDTH   (ADJ_WIDTH)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.iss      (iss),
		.iss_ix   (iss_ix),
		.path_rd  (path_rd_q),
		.adj_rd   (adj_rd_q),
		.weight   (w_q),
		.score_rd (score_rd_q),
		.pw_en    (pw_en),
		.pw_addr  (pw_addr),
		.pw_data  (pw_data),
		.sr_en    (sr_en),
		.sr_addr  (sr_addr),
		.sw_en    (sw_en),
		.sw_addr  (sw_addr),
		.sw_data  (sw_data),
		.busy     (mac_busy)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
			beta_q       <= BETA_RST;
			steps_q      <= STEPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NODE_COUNT: node_count_q <= cfg_data[6:0];
				REG_BETA:       beta_q       <= cfg_data;
				REG_STEPS:      steps_q      <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CLEAR;
			clr_q       <= '0;
			ea_q        <= '0;
			eb_q        <= '0;
			ci_q        <= '0;
			cj_q        <= '0;
			gi_q        <= '0;
			gx_q        <= '0;
			gj_q        <= '0;
			sc_q        <= '0;
			rb_q        <= 1'b0;
			q_ok_q      <= 1'b0;
			w_q         <= WEIGHT_ONE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == '1) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (accept) begin
						ea_q <= na;
						eb_q <= nb;
						unique case (in_data.command)
							CMD_EDGE: if (a_ok && b_ok) begin
								state_q <= E_WR1;
							end
							CMD_RUN: begin
								w_q  <= WEIGHT_ONE;
								sc_q <= '0;
								rb_q <= 1'b0;
								ci_q <= '0;
								cj_q <= '0;
								state_q <= (n == '0) ? C_DONE : C_INIT;
							end
							CMD_QUERY: begin
								q_ok_q  <= a_ok & b_ok;
								state_q <= Q_OUT;
							end
							default: ;
						endcase
					end
				end
				E_WR1: state_q <= E_RD2;
				E_RD2: state_q <= E_WR2;
				E_WR2: state_q <= IDLE;
				Q_OUT: begin
					if (out_free) begin
						out_valid_q      <= 1'b1;
						out_q.result_kind <= KIND_SCORE;
						out_q.pair_score <= q_ok_q ? score_rd_q : '0;
						state_q          <= IDLE;
					end
				end
				C_INIT: begin
					cj_q <= cj_q + NW'(1);
					if (cj_q == nm1) begin
						cj_q <= '0;
						ci_q <= ci_q + NW'(1);
						if (ci_q == nm1) begin
							state_q <= (steps_q == '0) ? C_DONE : C_WGT;
						end
					end
				end
				C_WGT: begin
					w_q     <= w_prod[63:32];
					gi_q    <= '0;
					gx_q    <= '0;
					gj_q    <= '0;
					state_q <= C_MUL;
				end
				C_MUL: begin
					gj_q <= gj_q + NW'(1);
					if (gj_q == nm1) begin
						gj_q <= '0;
						gx_q <= gx_q + NW'(1);
						if (gx_q == nm1) begin
							gx_q <= '0;
							gi_q <= gi_q + NW'(1);
							if (gi_q == nm1) begin
								state_q <= C_DRAIN;
							end
						end
					end
				end
				C_DRAIN: begin
					if (!mac_busy) begin
						rb_q <= ~rb_q;
						sc_q <= sc_q + 6'd1;
						state_q <= (sc_q + 6'd1 == steps_q) ? C_DONE : C_WGT;
					end
				end
				C_DONE: begin
					if (out_free) begin
						out_valid_q       <= 1'b1;
						out_q.result_kind <= KIND_DONE;
						out_q.pair_score  <= '0;
						state_q           <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the product pipeline only runs inside a computation step
	a_mac_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		mac_busy |-> (state_q == C_MUL || state_q == C_DRAIN))
		else $error("product pipeline busy outside a computation step");

	// a new result is only loaded from the query or done states
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == Q_OUT || $past(state_q) == C_DONE))
		else $error("result produced from an unexpected state");

	// a pending result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result lost or changed");

	// path write-back never targets the bank being read
	a_bank_split: assert property (@(posedge clk) disable iff (!arst_n)
		(path_we && path_re) |-> (path_wa[IW] != path_ra[IW]))
		else $error("path memory bank clash");

endmodule

### tb/sv/tb_katz_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_katz_checker
// Watches the command, result and register ports of the Katz index engine,
// keeps its own copy of the graph and the score matrix, works out the score
// or done result due for every accepted command and compares each accepted
// result against the oldest one still owed.
// ----------------------------------------------------------------------------
module tb_katz_checker import kie_pkg::*; (
	input  logic        clk,
	input  logic        in_valid,
	input  logic        in_stall,
	input  kie_in_t     in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  kie_out_t    out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	localparam int NODES = 64;
	localparam int DEPTH = NODES * NODES;

	// shadow registers and graph state
	logic [6:0]  nodes_reg = NODE_COUNT_RST;
	logic [31:0] beta_reg  = BETA_RST;
	logic [5:0]  steps_reg = STEPS_RST;
	logic [7:0]  adj   [DEPTH];
	logic [31:0] walks [DEPTH];
	logic [31:0] walks_nxt [DEPTH];
	logic [63:0] score [DEPTH];
	logic [31:0] len_weight = WEIGHT_ONE;

	kie_out_t owed_q [$];

	initial begin
		fail_count = 0;
		foreach (adj[k]) begin
			adj[k] = '0;
			score[k] = '0;
			walks[k] = '0;
		end
	end

	assign pending = owed_q.size();

	function automatic int active_nodes();
		return (nodes_reg > NODES) ? NODES : int'(nodes_reg);
	endfunction

	function automatic logic [31:0] walk_mac(logic [31:0] acc, logic [31:0] p,
			logic [7:0] a);
		logic [39:0] prod;
		logic [32:0] sum;
		prod = p * a;
		if (prod > 40'hFFFF_FFFF)
			prod = 40'hFFFF_FFFF;
		sum = acc + prod[31:0];
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	// one saturating increment of an adjacency entry
	task automatic bump_adj(int r, int c);
		if (adj[r * NODES + c] != 8'hFF)
			adj[r * NODES + c] = adj[r * NODES + c] + 8'd1;
	endtask

	// full truncated Katz sum over the nodes in use
	task automatic run_katz();
		int n;
		int k;
		logic [31:0] acc;
		logic [63:0] wprod;
		logic [64:0] ssum;
		n = active_nodes();
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++) begin
				walks[i * NODES + j] = (i == j) ? 32'd1 : 32'd0;
				score[i * NODES + j] = '0;
			end
		len_weight = WEIGHT_ONE;
		for (int s = 0; s < steps_reg; s++) begin
			wprod = len_weight * beta_reg + WEIGHT_ROUND;
			len_weight = wprod[63:32];
			for (int i = 0; i < n; i++)
				for (int x = 0; x < n; x++) begin
					acc = '0;
					for (int j = 0; j < n; j++)
						acc = walk_mac(acc, walks[i * NODES + j], adj[j * NODES + x]);
					walks_nxt[i * NODES + x] = acc;
				end
			for (int i = 0; i < n; i++)
				for (int j = 0; j < n; j++) begin
					k = i * NODES + j;
					walks[k] = walks_nxt[k];
					wprod = len_weight * walks[k];
					ssum = score[k] + wprod;
					score[k] = ssum[64] ? '1 : ssum[63:0];
				end
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// register writes
	always @(posedge clk) begin
		if (cfg_we) begin
			case (cfg_index)
				REG_NODE_COUNT: nodes_reg <= cfg_data[6:0];
				REG_BETA:       beta_reg  <= cfg_data;
				REG_STEPS:      steps_reg <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// accepted commands
	always @(posedge clk) begin
		int n;
		kie_out_t res;
		if (in_valid && !in_stall) begin
			n = active_nodes();
			case (in_data.command)
				CMD_EDGE: begin
					if (in_data.node_a < n && in_data.node_b < n) begin
						bump_adj(int'(in_data.node_a), int'(in_data.node_b));
						bump_adj(int'(in_data.node_b), int'(in_data.node_a));
					end
				end
				CMD_RUN: begin
					run_katz();
					res.result_kind = KIND_DONE;
					res.pair_score = '0;
					owed_q = {owed_q, res};
				end
				CMD_QUERY: begin
					res.result_kind = KIND_SCORE;
					res.pair_score = (in_data.node_a < n && in_data.node_b < n) ?
						score[in_data.node_a * NODES + in_data.node_b] : 64'd0;
					owed_q = {owed_q, res};
				end
				default: ;
			endcase
		end
	end

	// accepted results
	always @(posedge clk) begin
		kie_out_t want;
		if (out_valid && !out_stall) begin
			if (owed_q.size() == 0) begin
				report_mismatch("unexpected result", out_data.pair_score, 64'd0);
			end else begin
				want = owed_q.pop_front();
				if (out_data.result_kind !== want.result_kind)
					report_mismatch("result_kind", 64'(out_data.result_kind),
						64'(want.result_kind));
				if (out_data.pair_score !== want.pair_score)
					report_mismatch("pair_score", out_data.pair_score, want.pair_score);
			end
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the Katz index engine: a directed opening, then phases of
// random edges, queries and computations under several register settings,
// with random gaps on both channels. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb_top;
	import kie_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	kie_in_t     in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	kie_out_t    out_data;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_NODE_COUNT;
	logic [31:0] cfg_data = '0;
	int          fail_count;
	int          pending;
	int          tx_gap_pct = 27;
	int          rx_stall_pct = 48;
	int          sent = 0;

	always #5 clk = ~clk;

	katz_index_engine_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tb_katz_checker chk (
		.clk(clk), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < rx_stall_pct);

	// idling profile follows progress through the run
	always @(posedge clk) begin
		if (sent < 550) begin
			tx_gap_pct <= 27;
			rx_stall_pct <= 48;
		end else if (sent < 1100) begin
			tx_gap_pct <= 48;
			rx_stall_pct <= 27;
		end else begin
			tx_gap_pct <= 0;
			rx_stall_pct <= 0;
		end
	end

	task automatic send_cmd(logic [1:0] cmd, logic [5:0] a, logic [5:0] b);
		while ($urandom_range(99) < tx_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{command: cmd, node_a: a, node_b: b};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold off until every result is in, and long enough after for a trailing edge update to finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [5:0] pick_node(int n);
		if (n > 0 && $urandom_range(99) < 85)
			return 6'($urandom_range(n - 1));
		return 6'($urandom_range(63));
	endfunction

	// one setting: registers, a compute so every score in range is written,
	// then random traffic
	task automatic run_phase(logic [6:0] nodes, logic [31:0] beta, logic [5:0] steps,
			int count, bit allow_run);
		int n;
		int r;
		drain();
		write_reg(REG_NODE_COUNT, {25'd0, nodes});
		write_reg(REG_BETA, beta);
		write_reg(REG_STEPS, {26'd0, steps});
		n = (nodes > 64) ? 64 : int'(nodes);
		send_cmd(CMD_RUN, '0, '0);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 55)
				send_cmd(CMD_EDGE, pick_node(n), pick_node(n));
			else if (r < 88 || (r < 92 && !allow_run))
				send_cmd(CMD_QUERY, pick_node(n), pick_node(n));
			else if (r < 92)
				send_cmd(CMD_RUN, pick_node(n), pick_node(n));
			else
				send_cmd(CMD_RSVD, pick_node(n), pick_node(n));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: two nodes, deep sum, full beta
		write_reg(REG_NODE_COUNT, 32'd2);
		write_reg(REG_BETA, 32'hFFFF_FFFF);
		write_reg(REG_STEPS, 32'd63);
		send_cmd(CMD_RUN, 6'd0, 6'd0);
		send_cmd(CMD_EDGE, 6'd0, 6'd0);
		send_cmd(CMD_EDGE, 6'd0, 6'd1);
		send_cmd(CMD_EDGE, 6'd1, 6'd0);
		send_cmd(CMD_EDGE, 6'd5, 6'd63);
		send_cmd(CMD_EDGE, 6'd63, 6'd63);
		send_cmd(CMD_RSVD, 6'd63, 6'd63);
		send_cmd(CMD_RUN, 6'd63, 6'd0);
		send_cmd(CMD_QUERY, 6'd0, 6'd0);
		send_cmd(CMD_QUERY, 6'd0, 6'd1);
		send_cmd(CMD_QUERY, 6'd1, 6'd0);
		send_cmd(CMD_QUERY, 6'd1, 6'd1);
		send_cmd(CMD_QUERY, 6'd63, 6'd0);
		send_cmd(CMD_QUERY, 6'd0, 6'd63);
		send_cmd(CMD_QUERY, 6'd2, 6'd1);

		// random phases; the widest graphs (64 nodes) get only short computations: a single one-step run, or zero-step runs
		run_phase(7'd2, 32'hFFFF_FFFF, 6'd63, 300, 1'b1);
		run_phase(7'd5, BETA_RST, STEPS_RST, 260, 1'b1);
		run_phase(7'd8, 32'h8000_0000, 6'd10, 260, 1'b1);
		run_phase(7'd1, 32'd0, 6'd1, 90, 1'b1);
		run_phase(7'd0, 32'd123, 6'd5, 40, 1'b1);
		run_phase(7'd127, 32'h1000_0000, 6'd1, 40, 1'b0);
		run_phase(7'd64, 32'h4000_0000, 6'd0, 60, 1'b1);
		run_phase(7'd3, $urandom, 6'd6, 300, 1'b1);
		run_phase(7'd16, $urandom, 6'd3, 270, 1'b1);

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// run limit
	initial begin
		#80ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
hdl/kie_pkg.sv
hdl/kie_mac_pipe.sv
hdl/katz_index_engine_unit.sv
tb/sv/tb_katz_checker.sv
tb/sv/tb_top.sv
